FILE: hw/rtl/aeag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeag_pkg - shared types and constants of the array element address generator
// Field types, operation codes, default sizes and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package aeag_pkg;

	localparam int MAX_ARRAYS_DEF = 16;
	localparam int MAX_DIMS_DEF   = 8;

	typedef logic [1:0]         opcode_t;
	typedef logic [3:0]         arr_id_t;
	typedef logic [2:0]         dim_num_t;
	typedef logic [3:0]         dim_cnt_t;
	typedef logic [15:0]        esize_t;
	typedef logic [31:0]        word_t;
	typedef logic signed [31:0] sword_t;

	localparam opcode_t OP_HEADER = 2'd0;
	localparam opcode_t OP_BOUNDS = 2'd1;
	localparam opcode_t OP_INDEX  = 2'd2;

	typedef struct packed {
		opcode_t  operation;
		arr_id_t  array_id;
		dim_num_t dim_number;
		word_t    base_address;
		esize_t   element_bytes;
		dim_cnt_t dim_count;
		sword_t   lower_bound;
		sword_t   upper_bound;
		sword_t   index_value;
	} req_t;

	typedef struct packed {
		logic wr_header;
		logic wr_bounds;
		logic capture;
		logic mac;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic dec_header;
		logic dec_bounds;
		logic dec_index;
		logic last;
		logic out_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/aeag_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeag_req_if - request channel
// Valid/ready channel that carries define and index items.
// ----------------------------------------------------------------------------
interface aeag_req_if;
	import aeag_pkg::*;

	logic     valid;
	logic     ready;
	opcode_t  operation;
	arr_id_t  array_id;
	dim_num_t dim_number;
	word_t    base_address;
	esize_t   element_bytes;
	dim_cnt_t dim_count;
	sword_t   lower_bound;
	sword_t   upper_bound;
	sword_t   index_value;

	modport source (
		output valid, operation, array_id, dim_number, base_address,
		       element_bytes, dim_count, lower_bound, upper_bound, index_value,
		input  ready
	);
	modport sink (
		input  valid, operation, array_id, dim_number, base_address,
		       element_bytes, dim_count, lower_bound, upper_bound, index_value,
		output ready
	);
endinterface
`default_nettype wire

FILE: hw/rtl/aeag_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeag_rsp_if - result channel
// Valid/ready channel that carries completed element addresses.
// ----------------------------------------------------------------------------
interface aeag_rsp_if;
	import aeag_pkg::*;

	logic    valid;
	logic    ready;
	arr_id_t ref_array;
	word_t   element_address;

	modport source (output valid, ref_array, element_address, input ready);
	modport sink (input valid, ref_array, element_address, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/aeag_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeag_ctrl - sequencing controller
// Accepts items, issues table writes, the offset multiply-accumulate and
// the final address step to the datapath.
// ----------------------------------------------------------------------------
module aeag_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  aeag_pkg::dp_sts_t sts,
	output aeag_pkg::dp_cmd_t cmd
);
	import aeag_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MAC  = 3'b010,
		ST_ADDR = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.wr_header = sts.dec_header;
					cmd.wr_bounds = sts.dec_bounds;
					cmd.capture   = sts.dec_index;
					if (sts.dec_index) begin
						state_d = ST_MAC;
					end
				end
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				state_d = sts.last ? ST_ADDR : ST_IDLE;
			end
			ST_ADDR: begin
				// hold the address step until the output register can take it
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_capture_then_mac: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_MAC)
		else $error("index item not followed by accumulate step");

	a_mac_single: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |=> state_q != ST_MAC)
		else $error("accumulate step lasted more than one cycle");

	a_addr_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR) && !sts.out_busy |=> state_q == ST_IDLE)
		else $error("address step stuck with free output register");

endmodule
`default_nettype wire

FILE: hw/rtl/aeag_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeag_dpath - descriptor tables and address arithmetic
// Holds descriptor tables, the bounds memories, the running offset and
// dimension counter, the multiply-accumulate and the output register.
// ----------------------------------------------------------------------------
module aeag_dpath #(
	parameter int MAX_ARRAYS = aeag_pkg::MAX_ARRAYS_DEF,
	parameter int MAX_DIMS   = aeag_pkg::MAX_DIMS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  aeag_pkg::req_t     req_item,
	input  aeag_pkg::dp_cmd_t  cmd,
	output aeag_pkg::dp_sts_t  sts,
	input  wire                rsp_ready,
	output logic               rsp_valid,
	output aeag_pkg::arr_id_t  ref_array,
	output aeag_pkg::word_t    element_address
);
	import aeag_pkg::*;

	localparam int AW    = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
	localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DEPTH = MAX_ARRAYS * (2 ** DW);
	localparam logic [8:0] ARR_LIMIT = 9'(MAX_ARRAYS);
	localparam logic [4:0] DIM_LIMIT = 5'(MAX_DIMS);

	// descriptor storage, undefined until written
	word_t    base_mem [MAX_ARRAYS];
	esize_t   esize_mem [MAX_ARRAYS];
	dim_cnt_t dims_mem [MAX_ARRAYS];
	word_t    low_mem [DEPTH];
	word_t    ext_mem [DEPTH];

	word_t    base_rd_q;
	esize_t   esize_rd_q;
	dim_cnt_t dims_rd_q;
	word_t    low_rd_q;
	word_t    ext_rd_q;
	word_t    idx_q;
	arr_id_t  ref_id_q;

	word_t         offset_q;
	logic [DW-1:0] cnt_q;

	logic    rsp_valid_q;
	arr_id_t rsp_ref_q;
	word_t   rsp_addr_q;

	logic [8:0]         id_wide;
	logic [3:0]         dn_wide;
	logic [AW-1:0]      id_idx;
	logic [DW-1:0]      dn_idx;
	logic               id_ok;
	logic               dn_ok;
	dim_cnt_t           dims_clamped;
	word_t              extent;
	logic [AW+DW-1:0]   wr_addr;
	logic [AW+DW-1:0]   rd_addr;
	logic [4:0]         cnt_p1;
	word_t              mac_prod;
	word_t              mac_sum;
	word_t              addr_prod;
	word_t              addr_sum;

	assign id_wide = {5'b0, req_item.array_id};
	assign dn_wide = {1'b0, req_item.dim_number};
	assign id_idx  = id_wide[AW-1:0];
	assign dn_idx  = dn_wide[DW-1:0];
	assign id_ok   = id_wide < ARR_LIMIT;
	assign dn_ok   = {2'b0, req_item.dim_number} < DIM_LIMIT;
	assign wr_addr = {id_idx, dn_idx};
	assign rd_addr = {id_idx, cnt_q};

	always_comb begin
		dims_clamped = req_item.dim_count;
		if (req_item.dim_count == '0) begin
			dims_clamped = 4'd1;
		end else if ({1'b0, req_item.dim_count} > DIM_LIMIT) begin
			dims_clamped = 4'(MAX_DIMS);
		end
	end

	assign extent = word_t'(req_item.upper_bound) - word_t'(req_item.lower_bound) + 32'd1;

	assign sts.dec_header = (req_item.operation == OP_HEADER) && id_ok;
	assign sts.dec_bounds = (req_item.operation == OP_BOUNDS) && id_ok && dn_ok;
	assign sts.dec_index  = (req_item.operation == OP_INDEX) && id_ok;

	// reference completes on the array's last dimension or the table's last
	assign cnt_p1   = 5'(cnt_q) + 5'd1;
	assign sts.last = (cnt_p1 >= {1'b0, dims_rd_q}) || (cnt_p1 >= DIM_LIMIT);
	assign sts.out_busy = rsp_valid_q && !rsp_ready;

	// header tables
	always_ff @(posedge clk) begin
		if (cmd.wr_header) begin
			base_mem[id_idx]  <= req_item.base_address;
			esize_mem[id_idx] <= req_item.element_bytes;
			dims_mem[id_idx]  <= dims_clamped;
		end
		if (cmd.capture) begin
			base_rd_q  <= base_mem[id_idx];
			esize_rd_q <= esize_mem[id_idx];
			dims_rd_q  <= dims_mem[id_idx];
		end
	end

	// bounds memories, one write and one registered read port each
	always_ff @(posedge clk) begin
		if (cmd.wr_bounds) begin
			low_mem[wr_addr] <= word_t'(req_item.lower_bound);
		end
		if (cmd.capture) begin
			low_rd_q <= low_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_bounds) begin
			ext_mem[wr_addr] <= extent;
		end
		if (cmd.capture) begin
			ext_rd_q <= ext_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q    <= word_t'(req_item.index_value);
			ref_id_q <= req_item.array_id;
		end
	end

	// horner step: offset * extent + (index - lower)
	assign mac_prod = offset_q * ext_rd_q;
	assign mac_sum  = mac_prod + (idx_q - low_rd_q);

	assign addr_prod = {16'b0, esize_rd_q} * offset_q;
	assign addr_sum  = base_rd_q + addr_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			cnt_q    <= '0;
		end else if (cmd.finish) begin
			offset_q <= '0;
			cnt_q    <= '0;
		end else if (cmd.mac) begin
			offset_q <= mac_sum;
			if (!sts.last) begin
				cnt_q <= cnt_q + DW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_ref_q  <= ref_id_q;
			rsp_addr_q <= addr_sum;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign ref_array       = rsp_ref_q;
	assign element_address = rsp_addr_q;

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid_q && (offset_q == '0) && (cnt_q == '0))
		else $error("completed reference did not clear offset and counter");

	a_cnt_steps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac && !sts.last |=> cnt_q == $past(cnt_q) + DW'(1))
		else $error("dimension counter did not advance");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		5'(cnt_q) < DIM_LIMIT)
		else $error("dimension counter beyond dimension limit");

endmodule
`default_nettype wire

FILE: hw/rtl/array_element_address_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_element_address_generator - row-major element address generator
// Keeps array descriptors and turns a sequence of per-dimension index
// items into base + element_size * offset.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    operation, array_id, dim_number, base_address,
//                                element_bytes, dim_count, lower_bound,
//                                upper_bound, index_value
//   rsp      out  valid/ready    ref_array, element_address
//
// define items write the tables when taken; an index item reads the bounds
// memory, then does one multiply-accumulate; the last index item of a reference
// then does the element size multiply into the output register.
// the final step waits while the output register holds an untaken result.
// reset clears control state only; descriptor tables are not cleared.
// ----------------------------------------------------------------------------
module array_element_address_generator #(
	parameter int MAX_ARRAYS = aeag_pkg::MAX_ARRAYS_DEF,
	parameter int MAX_DIMS   = aeag_pkg::MAX_DIMS_DEF
) (
	input wire         clk,
	input wire         arst_n,
	aeag_req_if.sink   req,
	aeag_rsp_if.source rsp
);
	import aeag_pkg::*;

	req_t    req_item;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign req_item.operation     = req.operation;
	assign req_item.array_id      = req.array_id;
	assign req_item.dim_number    = req.dim_number;
	assign req_item.base_address  = req.base_address;
	assign req_item.element_bytes = req.element_bytes;
	assign req_item.dim_count     = req.dim_count;
	assign req_item.lower_bound   = req.lower_bound;
	assign req_item.upper_bound   = req.upper_bound;
	assign req_item.index_value   = req.index_value;

	aeag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aeag_dpath #(
		.MAX_ARRAYS (MAX_ARRAYS),
		.MAX_DIMS   (MAX_DIMS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_item        (req_item),
		.cmd             (cmd),
		.sts             (sts),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.ref_array       (rsp.ref_array),
		.element_address (rsp.element_address)
	);

endmodule
`default_nettype wire

FILE: sim/tb_array_element_address_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_element_address_generator - self-checking bench for the address generator
// A directed table of define and index items runs first, then random
// array definitions and references with random gaps on both channels
// and one long result stall. Each address is checked against a local
// row-major address calculation, or against the value the directed table gives.
// ----------------------------------------------------------------------------
module tb_array_element_address_generator;
	import aeag_pkg::*;

	localparam int N_ARRAYS     = MAX_ARRAYS_DEF;
	localparam int N_DIMS       = MAX_DIMS_DEF;
	localparam int N_DIRECTED   = 25;
	localparam int RANDOM_ITEMS = 700;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 300000;
	localparam opcode_t OP_UNUSED = 2'd3;

	typedef struct packed {
		arr_id_t arr;
		word_t   addr;
	} addr_rsp_t;

	typedef struct {
		req_t      stim;
		bit        typed;
		addr_rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	aeag_req_if req_bus();
	aeag_rsp_if rsp_bus();

	array_element_address_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	// descriptor copy, plus which entries have been written
	word_t    base_tab [N_ARRAYS];
	esize_t   esz_tab  [N_ARRAYS];
	dim_cnt_t dims_tab [N_ARRAYS];
	word_t    low_tab  [N_ARRAYS*N_DIMS];
	word_t    ext_tab  [N_ARRAYS*N_DIMS];
	bit       hdr_ok   [N_ARRAYS];
	bit       bnd_ok   [N_ARRAYS*N_DIMS];
	word_t    run_ofs = '0;
	dim_cnt_t dim_ctr = '0;

	addr_rsp_t pending_addr[$];
	dir_row_t  directed_rows[N_DIRECTED];

	int cycles       = 0;
	int mismatches   = 0;
	int results_seen = 0;
	int n_define     = 0;
	int n_index      = 0;
	int n_ignored    = 0;
	bit holding      = 1'b0;
	bit hold_done    = 1'b0;
	bit tx_burst     = 1'b0;
	bit rx_burst     = 1'b0;

	function automatic bit predict_address(input req_t it, output addr_rsp_t res);
		int       slot;
		int       d;
		dim_cnt_t dc;
		res = '0;
		case (it.operation)
			OP_HEADER: begin
				dc = it.dim_count;
				if (dc == 0)
					dc = 4'd1;
				if (dc > N_DIMS)
					dc = dim_cnt_t'(N_DIMS);
				base_tab[it.array_id] = it.base_address;
				esz_tab[it.array_id]  = it.element_bytes;
				dims_tab[it.array_id] = dc;
				hdr_ok[it.array_id]   = 1'b1;
				return 1'b0;
			end
			OP_BOUNDS: begin
				slot = it.array_id * N_DIMS + it.dim_number;
				low_tab[slot] = word_t'(it.lower_bound);
				ext_tab[slot] = word_t'(it.upper_bound) - word_t'(it.lower_bound) + 1;
				bnd_ok[slot]  = 1'b1;
				return 1'b0;
			end
			OP_INDEX: begin
				d    = int'(dim_ctr);
				slot = it.array_id * N_DIMS + d;
				// horner step, everything wraps at 32 bits
				run_ofs = run_ofs * ext_tab[slot] + (word_t'(it.index_value) - low_tab[slot]);
				if (d + 1 >= dims_tab[it.array_id] || d + 1 >= N_DIMS) begin
					res.arr  = it.array_id;
					res.addr = base_tab[it.array_id] + word_t'(esz_tab[it.array_id]) * run_ofs;
					run_ofs  = '0;
					dim_ctr  = '0;
					return 1'b1;
				end
				dim_ctr = dim_cnt_t'(d + 1);
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// an index item may only read descriptor entries that were written
	function automatic bit can_index(input arr_id_t id);
		return hdr_ok[id] && bnd_ok[id * N_DIMS + dim_ctr];
	endfunction

	function automatic req_t noise_item();
		req_t it;
		it.operation     = opcode_t'($urandom_range(0, 3));
		it.array_id      = arr_id_t'($urandom_range(0, 15));
		it.dim_number    = dim_num_t'($urandom_range(0, 7));
		it.base_address  = $urandom;
		it.element_bytes = esize_t'($urandom_range(0, 65535));
		it.dim_count     = dim_cnt_t'($urandom_range(0, 15));
		it.lower_bound   = $urandom;
		it.upper_bound   = $urandom;
		it.index_value   = $urandom;
		return it;
	endfunction

	function automatic req_t header_item(input arr_id_t id, input word_t base,
			input esize_t esz, input dim_cnt_t dc, input bit noisy);
		req_t it;
		it               = noisy ? noise_item() : '0;
		it.operation     = OP_HEADER;
		it.array_id      = id;
		it.base_address  = base;
		it.element_bytes = esz;
		it.dim_count     = dc;
		return it;
	endfunction

	function automatic req_t bounds_item(input arr_id_t id, input dim_num_t dn,
			input sword_t lo, input sword_t hi, input bit noisy);
		req_t it;
		it             = noisy ? noise_item() : '0;
		it.operation   = OP_BOUNDS;
		it.array_id    = id;
		it.dim_number  = dn;
		it.lower_bound = lo;
		it.upper_bound = hi;
		return it;
	endfunction

	function automatic req_t index_item(input arr_id_t id, input sword_t v, input bit noisy);
		req_t it;
		it             = noisy ? noise_item() : '0;
		it.operation   = OP_INDEX;
		it.array_id    = id;
		it.index_value = v;
		return it;
	endfunction

	// mostly in-range indexes, now and then anything at all
	function automatic sword_t pick_index(input arr_id_t id);
		int    slot;
		word_t ext;
		slot = id * N_DIMS + dim_ctr;
		ext  = ext_tab[slot];
		if (ext != 0 && ext <= 4096 && $urandom_range(0, 7) != 0)
			return sword_t'(low_tab[slot] + $urandom_range(0, ext - 1));
		return $urandom;
	endfunction

	task automatic random_bounds(output sword_t lo, output sword_t hi);
		case ($urandom_range(0, 7))
			0: begin
				lo = $urandom;
				hi = $urandom;
			end
			1: begin
				lo = 32'h80000000;
				hi = 32'h7FFFFFFF;
			end
			2: begin
				hi = $urandom_range(0, 100);
				lo = hi + $urandom_range(1, 50);
			end
			default: begin
				lo = $urandom_range(0, 1) ? $urandom : sword_t'($urandom_range(0, 40)) - 20;
				hi = lo + $urandom_range(0, 15);
			end
		endcase
	endtask

	// offer one item, wait for it to be taken, then record what it should produce
	task automatic send_item(input req_t it, input bit typed, input addr_rsp_t want,
			output bit produced);
		int        gap;
		addr_rsp_t res;
		gap = (holding || tx_burst) ? 0 : $urandom_range(0, 18);
		if ($urandom_range(0, 31) == 0)
			tx_burst = !tx_burst;
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.operation     <= it.operation;
		req_bus.array_id      <= it.array_id;
		req_bus.dim_number    <= it.dim_number;
		req_bus.base_address  <= it.base_address;
		req_bus.element_bytes <= it.element_bytes;
		req_bus.dim_count     <= it.dim_count;
		req_bus.lower_bound   <= it.lower_bound;
		req_bus.upper_bound   <= it.upper_bound;
		req_bus.index_value   <= it.index_value;
		req_bus.valid         <= 1'b1;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		produced = predict_address(it, res);
		if (typed) begin
			res      = want;
			produced = 1'b1;
		end
		if (produced)
			pending_addr = {pending_addr, res};
		case (it.operation)
			OP_HEADER, OP_BOUNDS: n_define++;
			OP_INDEX: n_index++;
			default: n_ignored++;
		endcase
		@(negedge clk);
	endtask

	task automatic define_array(input arr_id_t id);
		dim_cnt_t dc;
		esize_t   esz;
		int       nb;
		sword_t   lo;
		sword_t   hi;
		bit       produced;
		dc = dim_cnt_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) :
			$urandom_range(1, 4));
		case ($urandom_range(0, 7))
			0: esz = '0;
			1: esz = '1;
			default: esz = esize_t'($urandom_range(0, 65535));
		endcase
		send_item(header_item(id, $urandom, esz, dc, 1'b1), 1'b0, '0, produced);
		// sometimes leave the slots past the dimension count unwritten
		nb = ($urandom_range(0, 3) == 0) ? int'(dims_tab[id]) : N_DIMS;
		for (int d = 0; d < nb; d++) begin
			random_bounds(lo, hi);
			send_item(bounds_item(id, dim_num_t'(d), lo, hi, 1'b1), 1'b0, '0, produced);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// result side: random back-pressure, one long stall, in-order compare
	initial begin
		int        gap;
		addr_rsp_t want;
		rsp_bus.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = rx_burst ? 0 : $urandom_range(0, 18);
			if ($urandom_range(0, 31) == 0)
				rx_burst = !rx_burst;
			if (results_seen == 40 && !hold_done) begin
				holding       = 1'b1;
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holding       = 1'b0;
				hold_done     = 1'b1;
			end else if (gap > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_bus.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_bus.valid)
				@(posedge clk);
			if (pending_addr.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: array %0d address %h",
						rsp_bus.ref_array, rsp_bus.element_address);
			end else begin
				want = pending_addr.pop_front();
				if (want.arr != rsp_bus.ref_array || want.addr != rsp_bus.element_address) begin
					mismatches++;
					if (mismatches <= 10)
						$display("address mismatch: expected array %0d address %h, got %0d %h",
							want.arr, want.addr, rsp_bus.ref_array, rsp_bus.element_address);
				end
			end
			results_seen++;
			@(negedge clk);
		end
	end

	initial begin
		int        base_count;
		int        pick;
		arr_id_t   id;
		arr_id_t   id2;
		bit        done;
		bit        produced;
		sword_t    lo;
		sword_t    hi;
		arr_id_t   cand[$];

		arst_n                = 1'b0;
		req_bus.valid         = 1'b0;
		req_bus.operation     = OP_HEADER;
		req_bus.array_id      = '0;
		req_bus.dim_number    = '0;
		req_bus.base_address  = '0;
		req_bus.element_bytes = '0;
		req_bus.dim_count     = '0;
		req_bus.lower_bound   = '0;
		req_bus.upper_bound   = '0;
		req_bus.index_value   = '0;

		// one-dimensional array at the top of every range, reversed bounds
		directed_rows[0]  = '{header_item(4'd15, 32'hFFFFFFFF, 16'hFFFF, 4'd0, 1'b0), 1'b0, '0};
		directed_rows[1]  = '{bounds_item(4'd15, 3'd0, 32'h7FFFFFFF, 32'h80000000, 1'b0),
			1'b0, '0};
		directed_rows[2]  = '{index_item(4'd15, 32'h80000000, 1'b0), 1'b1,
			'{4'd15, 32'h0000FFFE}};
		directed_rows[3]  = '{'1, 1'b0, '0};
		// eight dimensions from an oversized count, zero element size
		directed_rows[4]  = '{header_item(4'd0, 32'h00001000, 16'h0000, 4'd15, 1'b0), 1'b0, '0};
		directed_rows[5]  = '{bounds_item(4'd0, 3'd0, 0, 3, 1'b0), 1'b0, '0};
		directed_rows[6]  = '{bounds_item(4'd0, 3'd1, -1, 1, 1'b0), 1'b0, '0};
		directed_rows[7]  = '{bounds_item(4'd0, 3'd2, 10, 12, 1'b0), 1'b0, '0};
		directed_rows[8]  = '{bounds_item(4'd0, 3'd3, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0),
			1'b0, '0};
		directed_rows[9]  = '{bounds_item(4'd0, 3'd4, -100, -90, 1'b0), 1'b0, '0};
		directed_rows[10] = '{bounds_item(4'd0, 3'd5, 0, 0, 1'b0), 1'b0, '0};
		directed_rows[11] = '{bounds_item(4'd0, 3'd6, 5, 2, 1'b0), 1'b0, '0};
		directed_rows[12] = '{bounds_item(4'd0, 3'd7, 32'h80000000, 32'h7FFFFFFF, 1'b0),
			1'b0, '0};
		directed_rows[13] = '{index_item(4'd0, 2, 1'b0), 1'b0, '0};
		directed_rows[14] = '{index_item(4'd0, -1, 1'b0), 1'b0, '0};
		directed_rows[15] = '{index_item(4'd0, 32'h7FFFFFFF, 1'b0), 1'b0, '0};
		directed_rows[16] = '{index_item(4'd0, 32'h80000000, 1'b0), 1'b0, '0};
		// define in the middle of a reference
		directed_rows[17] = '{bounds_item(4'd15, 3'd3, 0, 0, 1'b0), 1'b0, '0};
		directed_rows[18] = '{index_item(4'd0, -95, 1'b0), 1'b0, '0};
		directed_rows[19] = '{index_item(4'd0, 0, 1'b0), 1'b0, '0};
		directed_rows[20] = '{index_item(4'd0, 3, 1'b0), 1'b0, '0};
		directed_rows[21] = '{index_item(4'd0, 32'h7FFFFFFF, 1'b0), 1'b1,
			'{4'd0, 32'h00001000}};
		// index outside its bounds
		directed_rows[22] = '{header_item(4'd1, 32'h00000100, 16'd2, 4'd1, 1'b0), 1'b0, '0};
		directed_rows[23] = '{bounds_item(4'd1, 3'd0, -5, 5, 1'b0), 1'b0, '0};
		directed_rows[24] = '{index_item(4'd1, 7, 1'b0), 1'b1, '{4'd1, 32'h00000118}};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want,
				produced);

		base_count = n_define + n_index;
		while (n_define + n_index - base_count < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			cand.delete();
			for (int k = 0; k < N_ARRAYS; k++)
				if (can_index(arr_id_t'(k)))
					cand = {cand, arr_id_t'(k)};
			if (pick < 15 || cand.size() == 0) begin
				define_array(arr_id_t'($urandom_range(0, N_ARRAYS - 1)));
			end else if (pick < 75) begin
				// a full reference, with the odd foreign item mixed in
				id   = cand[$urandom_range(0, cand.size() - 1)];
				done = 1'b0;
				while (!done && can_index(id)) begin
					if ($urandom_range(0, 7) == 0) begin
						id2 = arr_id_t'($urandom_range(0, N_ARRAYS - 1));
						if ($urandom_range(0, 1) && can_index(id2)) begin
							send_item(index_item(id2, pick_index(id2), 1'b1), 1'b0, '0, produced);
						end else begin
							random_bounds(lo, hi);
							send_item(bounds_item(id2, dim_num_t'($urandom_range(0, 7)), lo, hi,
								1'b1), 1'b0, '0, produced);
						end
					end else begin
						send_item(index_item(id, pick_index(id), 1'b1), 1'b0, '0, done);
					end
				end
			end else if (pick < 85) begin
				id2 = arr_id_t'($urandom_range(0, N_ARRAYS - 1));
				random_bounds(lo, hi);
				send_item(bounds_item(id2, dim_num_t'($urandom_range(0, 7)), lo, hi, 1'b1),
					1'b0, '0, produced);
			end else if (pick < 93) begin
				send_item(header_item(arr_id_t'($urandom_range(0, N_ARRAYS - 1)), $urandom,
					esize_t'($urandom_range(0, 65535)), dim_cnt_t'($urandom_range(0, 15)),
					1'b1), 1'b0, '0, produced);
			end else begin
				// unused operation, must be dropped
				id2 = arr_id_t'($urandom_range(0, N_ARRAYS - 1));
				send_item(header_item(id2, $urandom, esize_t'($urandom_range(0, 65535)),
					dim_cnt_t'($urandom_range(0, 15)), 1'b1) | {OP_UNUSED, 155'd0},
					1'b0, '0, produced);
			end
		end
		req_bus.valid <= 1'b0;

		while (pending_addr.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d define, %0d index and %0d ignored items; %0d addresses compared",
			n_define, n_index, n_ignored, results_seen);
		$display("%0d mismatches in %0d cycles", mismatches, cycles);
		if (mismatches == 0 && pending_addr.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
